@@ rtl/core/cci_pkg.sv @@
// ----------------------------------------------------------------------------
// cci_pkg: shared types and constants for the coin/credit I/O controller
// Bus access codes, write commands, switch bit positions, word structs and
// the joystick remap table.
// ----------------------------------------------------------------------------
package cci_pkg;

  // Bus access codes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Write commands (taken when no ratio load is pending)
  localparam logic [2:0] CMD_LOAD_RATIO = 3'd1;
  localparam logic [2:0] CMD_CREDIT     = 3'd2;
  localparam logic [2:0] CMD_REMAP_OFF  = 3'd3;
  localparam logic [2:0] CMD_REMAP_ON   = 3'd4;
  localparam logic [2:0] CMD_SWITCH     = 3'd5;

  // Ratio load sequence: countdown values for the first three loaded fields; give1 takes the last count
  localparam logic [2:0] LOAD_NEED0 = 3'd4;
  localparam logic [2:0] LOAD_GIVE0 = 3'd3;
  localparam logic [2:0] LOAD_NEED1 = 3'd2;

  // Active-high switch level byte, bit positions
  localparam int SW_FIRE      = 0;
  localparam int SW_START_ONE = 2;
  localparam int SW_START_TWO = 3;
  localparam int SW_COIN_ONE  = 4;
  localparam int SW_COIN_TWO  = 5;
  localparam int SW_SERVICE   = 6;

  // Credit limits
  localparam logic [6:0] CREDIT_LIMIT      = 7'd99;
  localparam logic [6:0] FREE_PLAY_CREDITS = 7'd100;
  localparam logic [6:0] CREDIT_CEILING    = 7'd113;
  localparam logic [7:0] COIN_MAX          = 8'd255;

  // Input word
  typedef struct packed {
    logic [1:0] opcode;
    logic [2:0] write_data;
    logic       fire_button;
    logic       start_one;
    logic       start_two;
    logic       coin_one;
    logic       coin_two;
    logic       service_coin;
    logic       joy_right;
    logic       joy_left;
  } in_word_t;

  // Result of one access from the access logic
  typedef struct packed {
    logic       valid;
    logic [7:0] read_data;
    logic [6:0] credit_count;
  } access_res_t;

  // Joystick nibble remap
  function automatic logic [3:0] remap_lookup(input logic [3:0] joy);
    logic [3:0] r;
    unique case (joy)
      4'h0: r = 4'hf;
      4'h1: r = 4'he;
      4'h2: r = 4'hd;
      4'h3: r = 4'h5;
      4'h4: r = 4'hc;
      4'h5: r = 4'h9;
      4'h6: r = 4'h7;
      4'h7: r = 4'h6;
      4'h8: r = 4'hb;
      4'h9: r = 4'h3;
      4'ha: r = 4'ha;
      4'hb: r = 4'h4;
      4'hc: r = 4'h1;
      4'hd: r = 4'h2;
      4'he: r = 4'h0;
      default: r = 4'h8;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/cci_if.sv @@
// ----------------------------------------------------------------------------
// cci_in_if / cci_out_if: valid/ready channels of the coin/credit controller
// One interface per direction; the sink drives ready, the source the rest.
// ----------------------------------------------------------------------------
interface cci_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [2:0] write_data;
  logic       fire_button;
  logic       start_one;
  logic       start_two;
  logic       coin_one;
  logic       coin_two;
  logic       service_coin;
  logic       joy_right;
  logic       joy_left;

  modport source (
    output valid, opcode, write_data, fire_button, start_one, start_two,
           coin_one, coin_two, service_coin, joy_right, joy_left,
    input  ready
  );
  modport sink (
    input  valid, opcode, write_data, fire_button, start_one, start_two,
           coin_one, coin_two, service_coin, joy_right, joy_left,
    output ready
  );
endinterface

interface cci_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic [6:0] credit_count;

  modport source (output valid, read_data, credit_count, input ready);
  modport sink   (input valid, read_data, credit_count, output ready);
endinterface

@@ rtl/core/cci_access.sv @@
// ----------------------------------------------------------------------------
// cci_access: controller state and per-access logic
// Holds mode, read phase, credits, coin counters and ratios. Applies one
// access when go is high and presents the read result combinationally.
// ----------------------------------------------------------------------------
module cci_access import cci_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  in_word_t    item,
  output access_res_t res
);

  typedef enum logic [1:0] {
    MODE_SWITCH = 2'd0,
    MODE_CREDIT = 2'd1,
    MODE_GAME   = 2'd2
  } mode_t;

  typedef struct packed {
    logic [7:0] count;
    logic [2:0] gain;
  } coin_step_t;

  localparam logic [1:0] PH_SWITCHES = 2'd0;
  localparam logic [1:0] PH_JOY_ONE  = 2'd1;
  localparam logic [1:0] PH_JOY_TWO  = 2'd2;

  // One coin edge: saturating count, then trade coins for credits
  function automatic coin_step_t coin_step(input logic [7:0] cnt,
                                           input logic [2:0] need,
                                           input logic [2:0] give);
    coin_step_t s;
    logic [7:0] c;
    c = (cnt == COIN_MAX) ? cnt : cnt + 8'd1;
    s.count = c;
    s.gain  = 3'd0;
    if (c >= {5'd0, need}) begin
      s.count = c - {5'd0, need};
      s.gain  = give;
    end
    return s;
  endfunction

  mode_t      mode_r, mode_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [6:0] credits_r, credits_nxt;
  logic [7:0] coin_cnt0_r, coin_cnt0_nxt;
  logic [7:0] coin_cnt1_r, coin_cnt1_nxt;
  logic [2:0] need0_r, need0_nxt;
  logic [2:0] need1_r, need1_nxt;
  logic [2:0] give0_r, give0_nxt;
  logic [2:0] give1_r, give1_nxt;
  logic [2:0] countdown_r, countdown_nxt;
  logic       remap_r, remap_nxt;
  logic [7:0] prev_sw_r, prev_sw_nxt;
  logic [1:0] prev_btn_r, prev_btn_nxt;

  logic [7:0]  lv_sw, rise_sw;
  logic [3:0]  lv_btn;
  logic [1:0]  rise_btn;
  coin_step_t  step0, step1;
  logic [6:0]  cred_a;
  logic [14:0] prod;
  logic [3:0]  tens, ones, joy;
  logic [7:0]  read_data;

  // Next-state and read data for one access
  always_comb begin
    mode_nxt      = mode_r;
    phase_nxt     = phase_r;
    credits_nxt   = credits_r;
    coin_cnt0_nxt = coin_cnt0_r;
    coin_cnt1_nxt = coin_cnt1_r;
    need0_nxt     = need0_r;
    need1_nxt     = need1_r;
    give0_nxt     = give0_r;
    give1_nxt     = give1_r;
    countdown_nxt = countdown_r;
    remap_nxt     = remap_r;
    prev_sw_nxt   = prev_sw_r;
    prev_btn_nxt  = prev_btn_r;
    read_data     = 8'd0;

    lv_sw = {1'b0, item.service_coin, item.coin_two, item.coin_one,
             item.start_two, item.start_one, 1'b0, item.fire_button};
    rise_sw  = lv_sw & ~prev_sw_r;
    lv_btn   = {item.start_two, item.start_one, 1'b0, item.fire_button};
    rise_btn = lv_btn[1:0] & ~prev_btn_r;
    step0    = coin_step(coin_cnt0_r, need0_r, give0_r);
    step1    = coin_step(coin_cnt1_r, need1_r, give1_r);
    cred_a   = credits_r;
    prod     = 15'd0;
    tens     = 4'd0;
    ones     = 4'd0;
    joy      = 4'hf;

    if (go) begin
      unique case (item.opcode)
        OP_WRITE: begin
          if (countdown_r != 3'd0) begin
            // ratio load in progress
            unique case (countdown_r)
              LOAD_NEED0: need0_nxt = item.write_data;
              LOAD_GIVE0: give0_nxt = item.write_data;
              LOAD_NEED1: need1_nxt = item.write_data;
              default:    give1_nxt = item.write_data;
            endcase
            countdown_nxt = countdown_r - 3'd1;
          end else begin
            unique case (item.write_data)
              CMD_LOAD_RATIO: begin
                countdown_nxt = LOAD_NEED0;
                credits_nxt   = 7'd0;
              end
              CMD_CREDIT: begin
                mode_nxt  = MODE_CREDIT;
                phase_nxt = PH_SWITCHES;
              end
              CMD_REMAP_OFF: remap_nxt = 1'b0;
              CMD_REMAP_ON:  remap_nxt = 1'b1;
              CMD_SWITCH: begin
                mode_nxt  = MODE_SWITCH;
                phase_nxt = PH_SWITCHES;
              end
              default: ;
            endcase
          end
        end

        OP_READ: begin
          phase_nxt = (phase_r >= PH_JOY_TWO) ? PH_SWITCHES : phase_r + 2'd1;
          if (mode_r == MODE_SWITCH) begin
            // raw active-low switch byte, then joystick nibble
            if (phase_r == PH_SWITCHES) begin
              read_data = ~lv_sw;
            end else if (phase_r == PH_JOY_ONE) begin
              read_data = {4'hf, ~item.joy_left, 1'b1, ~item.joy_right, 1'b1};
            end
          end else if (phase_r == PH_SWITCHES) begin
            prev_sw_nxt = lv_sw;
            // coin counting, free play when no ratio is set
            if (need0_r != 3'd0) begin
              if (credits_r < CREDIT_LIMIT) begin
                if (rise_sw[SW_COIN_ONE]) begin
                  coin_cnt0_nxt = step0.count;
                  cred_a        = cred_a + {4'd0, step0.gain};
                end
                if (rise_sw[SW_COIN_TWO]) begin
                  coin_cnt1_nxt = step1.count;
                  cred_a        = cred_a + {4'd0, step1.gain};
                end
                if (rise_sw[SW_SERVICE]) begin
                  cred_a = cred_a + 7'd1;
                end
              end
            end else begin
              cred_a = FREE_PLAY_CREDITS;
            end
            // start buttons take credits
            if (mode_r == MODE_CREDIT) begin
              if (rise_sw[SW_START_ONE]) begin
                if (cred_a >= 7'd1) begin
                  cred_a   = cred_a - 7'd1;
                  mode_nxt = MODE_GAME;
                end
              end else if (rise_sw[SW_START_TWO]) begin
                if (cred_a >= 7'd2) begin
                  cred_a   = cred_a - 7'd2;
                  mode_nxt = MODE_GAME;
                end
              end
            end
            credits_nxt = cred_a;
            // BCD by reciprocal multiply, exact below 128
            prod      = {8'd0, cred_a} * 15'd205;
            tens      = prod[14:11];
            ones      = 4'(cred_a - 7'(tens) * 7'd10);
            read_data = {tens, ones};
          end else begin
            // joystick byte with fire edge and level bits, active low
            if (phase_r == PH_JOY_ONE) begin
              joy = {~item.joy_left, 1'b1, ~item.joy_right, 1'b1};
            end
            if (remap_r) begin
              joy = remap_lookup(joy);
            end
            if (phase_r == PH_JOY_ONE) begin
              prev_btn_nxt = {prev_btn_r[1], lv_btn[0]};
              read_data    = {2'b00, ~lv_btn[0], ~rise_btn[0], joy};
            end else begin
              prev_btn_nxt = {lv_btn[1], prev_btn_r[0]};
              read_data    = {2'b00, ~lv_btn[1], ~rise_btn[1], joy};
            end
          end
        end

        OP_CLEAR: begin
          mode_nxt      = MODE_SWITCH;
          phase_nxt     = PH_SWITCHES;
          credits_nxt   = 7'd0;
          coin_cnt0_nxt = 8'd0;
          coin_cnt1_nxt = 8'd0;
          need0_nxt     = 3'd0;
          need1_nxt     = 3'd0;
          give0_nxt     = 3'd0;
          give1_nxt     = 3'd0;
          countdown_nxt = 3'd0;
          remap_nxt     = 1'b0;
          prev_sw_nxt   = 8'd0;
          prev_btn_nxt  = 2'd0;
        end

        default: ;
      endcase
    end
  end

  assign res.valid        = (item.opcode == OP_READ);
  assign res.read_data    = read_data;
  assign res.credit_count = credits_nxt;

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_SWITCH;
      phase_r     <= PH_SWITCHES;
      credits_r   <= 7'd0;
      coin_cnt0_r <= 8'd0;
      coin_cnt1_r <= 8'd0;
      need0_r     <= 3'd0;
      need1_r     <= 3'd0;
      give0_r     <= 3'd0;
      give1_r     <= 3'd0;
      countdown_r <= 3'd0;
      remap_r     <= 1'b0;
      prev_sw_r   <= 8'd0;
      prev_btn_r  <= 2'd0;
    end else begin
      mode_r      <= mode_nxt;
      phase_r     <= phase_nxt;
      credits_r   <= credits_nxt;
      coin_cnt0_r <= coin_cnt0_nxt;
      coin_cnt1_r <= coin_cnt1_nxt;
      need0_r     <= need0_nxt;
      need1_r     <= need1_nxt;
      give0_r     <= give0_nxt;
      give1_r     <= give1_nxt;
      countdown_r <= countdown_nxt;
      remap_r     <= remap_nxt;
      prev_sw_r   <= prev_sw_nxt;
      prev_btn_r  <= prev_btn_nxt;
    end
  end

endmodule

@@ rtl/core/coin_credit_io_controller_top.sv @@
// Timing: an accepted word waits in the input register and is applied when the
// stage moves; a read's result word is then offered from the output register.
// Throughput: one word per cycle, but a read stalls on a full output register;
// the input and output registers let a new word in while a result still waits downstream.
// Reset: synchronous, active low; clears all controller state to switch mode.
// ----------------------------------------------------------------------------
// coin_credit_io_controller_top: coin/credit I/O controller
// Input register, access logic, output register.
// ----------------------------------------------------------------------------
module coin_credit_io_controller_top import cci_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  cci_in_if.sink     in_bus,
  cci_out_if.source  out_bus
);

  logic        in_valid_r;
  in_word_t    in_r;
  logic        out_valid_r;
  logic [7:0]  read_data_r;
  logic [6:0]  credit_count_r;
  logic        out_free;
  logic        stage_go;
  access_res_t res;

  // Stage moves unless it holds a read and the output register is full and not draining
  assign out_free     = !out_valid_r || out_bus.ready;
  assign stage_go     = in_valid_r && (out_free || !res.valid);
  assign in_bus.ready = !in_valid_r || stage_go;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      in_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      in_r.opcode       <= in_bus.opcode;
      in_r.write_data   <= in_bus.write_data;
      in_r.fire_button  <= in_bus.fire_button;
      in_r.start_one    <= in_bus.start_one;
      in_r.start_two    <= in_bus.start_two;
      in_r.coin_one     <= in_bus.coin_one;
      in_r.coin_two     <= in_bus.coin_two;
      in_r.service_coin <= in_bus.service_coin;
      in_r.joy_right    <= in_bus.joy_right;
      in_r.joy_left     <= in_bus.joy_left;
    end
  end

  cci_access u_access (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (stage_go),
    .item  (in_r),
    .res   (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stage_go && res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_go && res.valid) begin
      read_data_r    <= res.read_data;
      credit_count_r <= res.credit_count;
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.read_data    = read_data_r;
  assign out_bus.credit_count = credit_count_r;

`ifndef SYNTHESIS
  // A read must not leave the stage while a result is stuck downstream
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && res.valid && out_valid_r && !out_bus.ready) |-> !stage_go)
    else $error("read advanced into a full output register");

  // A read that advances shows up at the output next cycle
  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (stage_go && res.valid) |=> out_valid_r)
    else $error("advanced read produced no result word");

  // Credits never pass the ceiling
  a_credit_ceiling: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (credit_count_r <= CREDIT_CEILING))
    else $error("credit count above ceiling");

  // Writes and clears never create a result
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r && !(stage_go && res.valid)) |=> !out_valid_r)
    else $error("result word without a read");
`endif

endmodule
